### rtl/core/mcl_pkg.sv
// shared types, constants and register codes for the motor command limiter
package mcl_pkg;

  localparam int LANES  = 8;
  localparam int CMD_W  = 16;
  localparam int US_W   = 12;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  // lane arithmetic: command minus peak plus max_throttle needs two bits of headroom
  localparam int EXT_W  = CMD_W + 2;

  localparam logic [CNT_W-1:0] RST_MOTOR_COUNT  = CNT_W'(4);
  localparam logic [US_W-1:0]  RST_MAX_THROTTLE = US_W'(2000);
  localparam logic [US_W-1:0]  RST_MIN_THROTTLE = US_W'(1150);
  localparam logic [US_W-1:0]  RST_MIN_CHECK    = US_W'(1100);
  localparam logic [US_W-1:0]  RST_MIN_COMMAND  = US_W'(1000);

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic [US_W-1:0] us_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MOTOR_COUNT,
    REG_MAX_THROTTLE,
    REG_MIN_THROTTLE,
    REG_MIN_CHECK,
    REG_MIN_COMMAND
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] motor_count;
    us_t              max_throttle;
    us_t              min_throttle;
    us_t              min_check;
    us_t              min_command;
  } cfg_t;

  typedef struct packed {
    cmd_t peak;
    logic idle;
    logic armed;
  } frame_ctl_t;

endpackage

### rtl/core/mcl_if.sv
// handshake channels for motor frames and limited command frames
interface mcl_frame_if;
  logic             valid;
  logic             ready;
  mcl_pkg::cmd_t    motor_zero;
  mcl_pkg::cmd_t    motor_one;
  mcl_pkg::cmd_t    motor_two;
  mcl_pkg::cmd_t    motor_three;
  mcl_pkg::cmd_t    motor_four;
  mcl_pkg::cmd_t    motor_five;
  mcl_pkg::cmd_t    motor_six;
  mcl_pkg::cmd_t    motor_seven;
  mcl_pkg::us_t     throttle_stick;
  logic             direct_throttle;
  logic             armed;

  modport source (
    output valid, motor_zero, motor_one, motor_two, motor_three, motor_four,
           motor_five, motor_six, motor_seven, throttle_stick, direct_throttle, armed,
    input  ready
  );
  modport sink (
    input  valid, motor_zero, motor_one, motor_two, motor_three, motor_four,
           motor_five, motor_six, motor_seven, throttle_stick, direct_throttle, armed,
    output ready
  );
endinterface

interface mcl_limit_if;
  logic          valid;
  logic          ready;
  mcl_pkg::us_t  out_zero;
  mcl_pkg::us_t  out_one;
  mcl_pkg::us_t  out_two;
  mcl_pkg::us_t  out_three;
  mcl_pkg::us_t  out_four;
  mcl_pkg::us_t  out_five;
  mcl_pkg::us_t  out_six;
  mcl_pkg::us_t  out_seven;

  modport source (
    output valid, out_zero, out_one, out_two, out_three, out_four, out_five,
           out_six, out_seven,
    input  ready
  );
  modport sink (
    input  valid, out_zero, out_one, out_two, out_three, out_four, out_five,
           out_six, out_seven,
    output ready
  );
endinterface

### rtl/core/mcl_regs.sv
// apb configuration registers of the motor command limiter
module mcl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcl_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcl_pkg::DATA_W-1:0]  pwdata,
  output logic [mcl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mcl_pkg::cfg_t               cfg
);

  mcl_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = mcl_pkg::reg_idx_t'(paddr[mcl_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_count  <= mcl_pkg::RST_MOTOR_COUNT;
      cfg.max_throttle <= mcl_pkg::RST_MAX_THROTTLE;
      cfg.min_throttle <= mcl_pkg::RST_MIN_THROTTLE;
      cfg.min_check    <= mcl_pkg::RST_MIN_CHECK;
      cfg.min_command  <= mcl_pkg::RST_MIN_COMMAND;
    end else if (wr) begin
      case (idx)
        mcl_pkg::REG_MOTOR_COUNT:  cfg.motor_count  <= pwdata[mcl_pkg::CNT_W-1:0];
        mcl_pkg::REG_MAX_THROTTLE: cfg.max_throttle <= pwdata[mcl_pkg::US_W-1:0];
        mcl_pkg::REG_MIN_THROTTLE: cfg.min_throttle <= pwdata[mcl_pkg::US_W-1:0];
        mcl_pkg::REG_MIN_CHECK:    cfg.min_check    <= pwdata[mcl_pkg::US_W-1:0];
        mcl_pkg::REG_MIN_COMMAND:  cfg.min_command  <= pwdata[mcl_pkg::US_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mcl_pkg::REG_MOTOR_COUNT:  prdata = mcl_pkg::DATA_W'(cfg.motor_count);
      mcl_pkg::REG_MAX_THROTTLE: prdata = mcl_pkg::DATA_W'(cfg.max_throttle);
      mcl_pkg::REG_MIN_THROTTLE: prdata = mcl_pkg::DATA_W'(cfg.min_throttle);
      mcl_pkg::REG_MIN_CHECK:    prdata = mcl_pkg::DATA_W'(cfg.min_check);
      mcl_pkg::REG_MIN_COMMAND:  prdata = mcl_pkg::DATA_W'(cfg.min_command);
      default:                   prdata = '0;
    endcase
  end

endmodule

### rtl/core/mcl_peak.sv
// largest command over the lanes in use, as a three-level compare tree
module mcl_peak (
  input  mcl_pkg::cmd_t              cmd [mcl_pkg::LANES],
  input  logic [mcl_pkg::CNT_W-1:0]  motor_count,
  output mcl_pkg::cmd_t              peak
);

  localparam mcl_pkg::cmd_t CMD_FLOOR = {1'b1, {(mcl_pkg::CMD_W-1){1'b0}}};

  mcl_pkg::cmd_t masked [mcl_pkg::LANES];
  mcl_pkg::cmd_t lvl1   [mcl_pkg::LANES/2];
  mcl_pkg::cmd_t lvl2   [mcl_pkg::LANES/4];

  always_comb begin
    // lane zero always takes part; an empty count blanks all outputs later anyway
    for (int i = 0; i < mcl_pkg::LANES; i++) begin
      if (i == 0 || mcl_pkg::CNT_W'(i) < motor_count) masked[i] = cmd[i];
      else masked[i] = CMD_FLOOR;
    end
    for (int i = 0; i < mcl_pkg::LANES/2; i++) begin
      lvl1[i] = (masked[2*i+1] > masked[2*i]) ? masked[2*i+1] : masked[2*i];
    end
    for (int i = 0; i < mcl_pkg::LANES/4; i++) begin
      lvl2[i] = (lvl1[2*i+1] > lvl1[2*i]) ? lvl1[2*i+1] : lvl1[2*i];
    end
    peak = (lvl2[1] > lvl2[0]) ? lvl2[1] : lvl2[0];
  end

endmodule

### rtl/core/mcl_lane.sv
// one lane: shift down by the excess, clamp, then idle and disarm overrides
module mcl_lane (
  input  mcl_pkg::cmd_t       cmd,
  input  logic                active,
  input  mcl_pkg::cfg_t       cfg,
  input  mcl_pkg::frame_ctl_t ctl,
  output mcl_pkg::us_t        result
);

  logic signed [mcl_pkg::EXT_W-1:0] cmd_x;
  logic signed [mcl_pkg::EXT_W-1:0] peak_x;
  logic signed [mcl_pkg::EXT_W-1:0] hi_x;
  logic signed [mcl_pkg::EXT_W-1:0] lo_x;
  logic signed [mcl_pkg::EXT_W-1:0] shifted;
  mcl_pkg::us_t                     clamped;

  always_comb begin
    cmd_x   = {{(mcl_pkg::EXT_W-mcl_pkg::CMD_W){cmd[mcl_pkg::CMD_W-1]}}, cmd};
    peak_x  = {{(mcl_pkg::EXT_W-mcl_pkg::CMD_W){ctl.peak[mcl_pkg::CMD_W-1]}}, ctl.peak};
    hi_x    = {{(mcl_pkg::EXT_W-mcl_pkg::US_W){1'b0}}, cfg.max_throttle};
    lo_x    = {{(mcl_pkg::EXT_W-mcl_pkg::US_W){1'b0}}, cfg.min_throttle};
    shifted = (peak_x > hi_x) ? (cmd_x - peak_x + hi_x) : cmd_x;
    // lower bound wins when the bounds cross
    if (shifted < lo_x) clamped = cfg.min_throttle;
    else if (shifted > hi_x) clamped = cfg.max_throttle;
    else clamped = shifted[mcl_pkg::US_W-1:0];
    if (!active) result = '0;
    else if (!ctl.armed) result = cfg.min_command;
    else if (ctl.idle) result = cfg.min_throttle;
    else result = clamped;
  end

endmodule

### rtl/core/motor_command_limiter.sv
// top level of the motor command limiter: peak stage, eight limiter lanes, output register
//
//  channel  direction  handshake          payload
//  frame    in         valid/ready        motor_zero..motor_seven, stick, direct, armed
//  limit    out        valid/ready        out_zero..out_seven
//  apb      in         psel/penable       five config registers at 4*index
//
// limit valid follows the frame transfer through the registers in order: the peak tree is
// registered, then the lanes feed the output register. one frame per cycle sustained
// while limit.ready is high. rst clears both stage valids and loads the defaults.
// a stalled output holds its register; the peak stage still takes a frame
// while its own slot is empty, so each side stalls only when both slots fill.
module motor_command_limiter (
  input  logic                        clk,
  input  logic                        rst,
  mcl_frame_if.sink                   frame,
  mcl_limit_if.source                 limit,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcl_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcl_pkg::DATA_W-1:0]  pwdata,
  output logic [mcl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  mcl_pkg::cfg_t       cfg;
  mcl_pkg::cmd_t       in_cmd  [mcl_pkg::LANES];
  mcl_pkg::cmd_t       peak;
  mcl_pkg::cmd_t       s1_cmd  [mcl_pkg::LANES];
  mcl_pkg::frame_ctl_t s1_ctl;
  logic                s1_valid;
  mcl_pkg::us_t        lane_res [mcl_pkg::LANES];
  mcl_pkg::us_t        res      [mcl_pkg::LANES];
  logic                out_valid;
  logic                out_free;
  logic                s1_free;

  mcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_cmd[0] = frame.motor_zero;
  assign in_cmd[1] = frame.motor_one;
  assign in_cmd[2] = frame.motor_two;
  assign in_cmd[3] = frame.motor_three;
  assign in_cmd[4] = frame.motor_four;
  assign in_cmd[5] = frame.motor_five;
  assign in_cmd[6] = frame.motor_six;
  assign in_cmd[7] = frame.motor_seven;

  mcl_peak u_peak (
    .cmd         (in_cmd),
    .motor_count (cfg.motor_count),
    .peak        (peak)
  );

  assign out_free    = !out_valid || limit.ready;
  assign s1_free     = !s1_valid || out_free;
  assign frame.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= frame.valid;
      if (out_free) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && s1_free) begin
      s1_cmd       <= in_cmd;
      s1_ctl.peak  <= peak;
      s1_ctl.idle  <= frame.direct_throttle && (frame.throttle_stick < cfg.min_check);
      s1_ctl.armed <= frame.armed;
    end
    if (s1_valid && out_free) res <= lane_res;
  end

  for (genvar g = 0; g < mcl_pkg::LANES; g++) begin : g_lane
    mcl_lane u_lane (
      .cmd    (s1_cmd[g]),
      .active (mcl_pkg::CNT_W'(g) < cfg.motor_count),
      .cfg    (cfg),
      .ctl    (s1_ctl),
      .result (lane_res[g])
    );
  end

  assign limit.valid     = out_valid;
  assign limit.out_zero  = res[0];
  assign limit.out_one   = res[1];
  assign limit.out_two   = res[2];
  assign limit.out_three = res[3];
  assign limit.out_four  = res[4];
  assign limit.out_five  = res[5];
  assign limit.out_six   = res[6];
  assign limit.out_seven = res[7];

endmodule
